// ===== design/gnss_link_health_supervisor_assert.svh =====
// Assertion macros used by the link health supervisor core.
// Needs signals named clk and arst_n in the module that includes it.
`ifndef GNSS_LINK_HEALTH_SUPERVISOR_ASSERT_SVH
`define GNSS_LINK_HEALTH_SUPERVISOR_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define GLHS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, held off during reset.
`define GLHS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/glhs_pkg.sv =====
// Types, codes and constants of the link health supervisor.
// Used by the front, the core and the top level.
package glhs_pkg;

	typedef enum logic [2:0] {
		MODE_INIT       = 3'd0,
		MODE_SEARCHING  = 3'd1,
		MODE_FIXED      = 3'd2,
		MODE_DEGRADED   = 3'd3,
		MODE_RECOVERING = 3'd4,
		MODE_FAULT      = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		FAULT_NONE    = 2'd0,
		FAULT_SILENCE = 2'd1,
		FAULT_SEARCH  = 2'd2,
		FAULT_LIMIT   = 2'd3
	} fault_t;

	// Input function codes.
	localparam logic [1:0] FUNC_SENTENCE = 2'd0;
	localparam logic [1:0] FUNC_TICK     = 2'd1;
	localparam logic [1:0] FUNC_START    = 2'd2;

	typedef enum logic [1:0] {
		KIND_SENTENCE,
		KIND_TICK,
		KIND_START,
		KIND_IGNORE
	} kind_t;

	typedef enum logic [2:0] {
		CFG_STARTUP_GRACE = 3'd0,
		CFG_SILENCE       = 3'd1,
		CFG_NO_FIX        = 3'd2,
		CFG_COOLDOWN      = 3'd3,
		CFG_MAX_RECOVERY  = 3'd4
	} cfg_idx_t;

	localparam logic [7:0]  MIN_SATS      = 8'd4;
	localparam logic [2:0]  MIN_FIX_KIND  = 3'd2;
	localparam logic [15:0] DOP_MIN_CENTI = 16'd1;
	localparam logic [15:0] DOP_MAX_CENTI = 16'd9998;

	localparam logic [31:0] STARTUP_GRACE_RST = 32'd60000;
	localparam logic [31:0] SILENCE_RST       = 32'd3000;
	localparam logic [31:0] NO_FIX_RST        = 32'd60000;
	localparam logic [31:0] COOLDOWN_RST      = 32'd10000;
	localparam logic [3:0]  MAX_RECOVERY_RST  = 4'd5;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] now_ms;
		logic        qual;
	} item_t;

	typedef struct packed {
		mode_t       mode;
		fault_t      fault_code;
		logic        fix_accepted;
		logic        reset_request;
		logic [3:0]  recovery_total;
		logic [15:0] silence_timeouts;
		logic [15:0] search_timeouts;
		logic        limit_reached;
	} result_t;

	// Wrap-safe timeout check: modular difference against the period.
	function automatic logic elapsed(input logic [31:0] since, input logic [31:0] period,
			input logic [31:0] now);
		logic [31:0] diff;
		diff = now - since;
		return diff >= period;
	endfunction

	function automatic logic [15:0] sat_inc16(input logic [15:0] v);
		return (v != 16'hFFFF) ? v + 16'd1 : v;
	endfunction

endpackage

// ===== design/glhs_fifo.sv =====
// Small flop-based queue of generic width and depth.
// No package dependency; used between front and core and on the result side.
module glhs_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr, do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	function automatic logic [PW-1:0] advance(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= advance(wr_ptr_q);
			end
			if (do_rd) begin
				rd_ptr_q <= advance(rd_ptr_q);
			end
			case ({do_wr, do_rd})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== design/glhs_front.sv =====
// Front end: accepts input items, decodes the function and qualifies the fix.
// Depends on glhs_pkg and glhs_fifo; the classified items wait in its queue.
module glhs_front import glhs_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  func,
	input  logic [31:0] now_ms,
	input  logic        parsed_present,
	input  logic        status_valid,
	input  logic        position_valid,
	input  logic [7:0]  sat_count,
	input  logic [15:0] hdop_centi,
	input  logic [15:0] pdop_centi,
	input  logic [2:0]  fix_kind,
	output logic        item_valid,
	output item_t       item,
	input  logic        item_take
);
	item_t                  cls;
	logic                   q_empty;
	logic [$bits(item_t)-1:0] q_data;

	always_comb begin
		cls.now_ms = now_ms;
		cls.qual   = parsed_present && status_valid && position_valid &&
			(sat_count >= MIN_SATS) && (fix_kind >= MIN_FIX_KIND) &&
			(hdop_centi >= DOP_MIN_CENTI) && (hdop_centi <= DOP_MAX_CENTI) &&
			(pdop_centi >= DOP_MIN_CENTI) && (pdop_centi <= DOP_MAX_CENTI);
		case (func)
			FUNC_SENTENCE: cls.kind = KIND_SENTENCE;
			FUNC_TICK:     cls.kind = KIND_TICK;
			FUNC_START:    cls.kind = KIND_START;
			default:       cls.kind = KIND_IGNORE;
		endcase
	end

	glhs_fifo #(
		.WIDTH ($bits(item_t)),
		.DEPTH (DEPTH)
	) u_item_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (cls),
		.full    (full),
		.rd_en   (item_take),
		.rd_data (q_data),
		.empty   (q_empty)
	);

	assign item_valid = !q_empty;
	assign item       = item_t'(q_data);

endmodule

// ===== design/glhs_core.sv =====
// Back end: holds the supervisor state and configuration, runs one item per cycle
// while results have room. Depends on glhs_pkg and the assertion macro header.
`include "gnss_link_health_supervisor_assert.svh"

module glhs_core import glhs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [2:0]  cfg_addr,
	input  logic [31:0] cfg_wdata,
	input  logic        item_valid,
	input  item_t       item,
	output logic        item_take,
	input  logic        res_full,
	output logic        res_write,
	output result_t     res
);
	logic [31:0] grace_q, silence_q, no_fix_q, cooldown_q;
	logic [3:0]  max_rec_q;

	mode_t       mode_q, mode_n;
	fault_t      fault_q, fault_n;
	logic        seen_sent_q, seen_sent_n;
	logic        seen_fix_q, seen_fix_n;
	logic        poll_fix_q, poll_fix_n;
	logic        limit_q, limit_n;
	logic [31:0] start_q, start_n;
	logic [31:0] last_sent_q, last_sent_n;
	logic [31:0] last_fix_q, last_fix_n;
	logic [31:0] last_rec_q, last_rec_n;
	logic [3:0]  rec_cnt_q, rec_cnt_n;
	logic [15:0] sil_cnt_q, sil_cnt_n;
	logic [15:0] srch_cnt_q, srch_cnt_n;

	logic        fire, pulse, accepted, go, rec_req;
	mode_t       tick_mode;
	fault_t      rec_code;
	logic        el_cool, el_grace, el_sil, el_nofix_start, el_nofix_last;

	assign fire      = item_valid && !res_full;
	assign item_take = fire;
	assign res_write = fire;

	// Five independent wrap-safe compares, all in parallel.
	assign el_cool        = elapsed(last_rec_q, cooldown_q, item.now_ms);
	assign el_grace       = elapsed(start_q, grace_q, item.now_ms);
	assign el_sil         = elapsed(last_sent_q, silence_q, item.now_ms);
	assign el_nofix_start = elapsed(start_q, no_fix_q, item.now_ms);
	assign el_nofix_last  = elapsed(last_fix_q, no_fix_q, item.now_ms);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grace_q    <= STARTUP_GRACE_RST;
			silence_q  <= SILENCE_RST;
			no_fix_q   <= NO_FIX_RST;
			cooldown_q <= COOLDOWN_RST;
			max_rec_q  <= MAX_RECOVERY_RST;
		end else if (cfg_wen) begin
			case (cfg_addr)
				CFG_STARTUP_GRACE: grace_q    <= cfg_wdata;
				CFG_SILENCE:       silence_q  <= cfg_wdata;
				CFG_NO_FIX:        no_fix_q   <= cfg_wdata;
				CFG_COOLDOWN:      cooldown_q <= cfg_wdata;
				CFG_MAX_RECOVERY:  max_rec_q  <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		mode_n      = mode_q;
		fault_n     = fault_q;
		seen_sent_n = seen_sent_q;
		seen_fix_n  = seen_fix_q;
		poll_fix_n  = poll_fix_q;
		limit_n     = limit_q;
		start_n     = start_q;
		last_sent_n = last_sent_q;
		last_fix_n  = last_fix_q;
		last_rec_n  = last_rec_q;
		rec_cnt_n   = rec_cnt_q;
		sil_cnt_n   = sil_cnt_q;
		srch_cnt_n  = srch_cnt_q;
		pulse       = 1'b0;
		accepted    = 1'b0;
		go          = 1'b0;
		rec_req     = 1'b0;
		rec_code    = FAULT_NONE;
		tick_mode   = mode_q;

		case (item.kind)
			KIND_SENTENCE: begin
				seen_sent_n = 1'b1;
				last_sent_n = item.now_ms;
				if (item.qual) begin
					accepted   = 1'b1;
					poll_fix_n = 1'b1;
					last_fix_n = item.now_ms;
				end
				if (poll_fix_q || item.qual) begin
					seen_fix_n = 1'b1;
					fault_n    = FAULT_NONE;
					mode_n     = MODE_FIXED;
				end else if (seen_fix_q) begin
					if (mode_q != MODE_RECOVERING) begin
						mode_n = MODE_DEGRADED;
					end
				end else if (mode_q != MODE_RECOVERING && mode_q != MODE_FAULT) begin
					mode_n = MODE_SEARCHING;
				end
			end
			KIND_TICK: begin
				poll_fix_n = 1'b0;
				if (mode_q == MODE_RECOVERING) begin
					go = el_cool;
					if (seen_fix_q) begin
						tick_mode = MODE_FIXED;
					end else if (seen_sent_q) begin
						tick_mode = MODE_SEARCHING;
					end else begin
						tick_mode = MODE_INIT;
					end
				end else begin
					go = (mode_q != MODE_FAULT);
				end
				if (go) begin
					mode_n = tick_mode;
					if (!seen_sent_q) begin
						if (el_grace) begin
							sil_cnt_n = sat_inc16(sil_cnt_q);
							rec_req   = 1'b1;
							rec_code  = FAULT_SILENCE;
						end
					end else if (el_sil) begin
						sil_cnt_n = sat_inc16(sil_cnt_q);
						rec_req   = 1'b1;
						rec_code  = FAULT_SILENCE;
					end else if (!seen_fix_q) begin
						if (el_nofix_start) begin
							srch_cnt_n = sat_inc16(srch_cnt_q);
							rec_req    = 1'b1;
							rec_code   = FAULT_SEARCH;
						end else if (tick_mode == MODE_INIT) begin
							mode_n = MODE_SEARCHING;
						end
					end else if (tick_mode == MODE_DEGRADED && el_nofix_last) begin
						srch_cnt_n = sat_inc16(srch_cnt_q);
						rec_req    = 1'b1;
						rec_code   = FAULT_SEARCH;
					end
					// Recovery request: fault if the budget is spent, else reset and recover.
					if (rec_req) begin
						if (rec_cnt_q >= max_rec_q) begin
							fault_n = FAULT_LIMIT;
							limit_n = 1'b1;
							mode_n  = MODE_FAULT;
						end else begin
							pulse       = 1'b1;
							seen_sent_n = 1'b0;
							seen_fix_n  = 1'b0;
							fault_n     = rec_code;
							rec_cnt_n   = rec_cnt_q + 4'd1;
							last_rec_n  = item.now_ms;
							mode_n      = MODE_RECOVERING;
						end
					end
				end
			end
			KIND_START: begin
				mode_n      = MODE_INIT;
				fault_n     = FAULT_NONE;
				seen_sent_n = 1'b0;
				seen_fix_n  = 1'b0;
				poll_fix_n  = 1'b0;
				limit_n     = 1'b0;
				start_n     = item.now_ms;
				last_sent_n = '0;
				last_fix_n  = '0;
				last_rec_n  = '0;
				rec_cnt_n   = '0;
				sil_cnt_n   = '0;
				srch_cnt_n  = '0;
				pulse       = 1'b1;
			end
			default: ;
		endcase

		res.mode             = mode_n;
		res.fault_code       = fault_n;
		res.fix_accepted     = accepted;
		res.reset_request    = pulse;
		res.recovery_total   = rec_cnt_n;
		res.silence_timeouts = sil_cnt_n;
		res.search_timeouts  = srch_cnt_n;
		res.limit_reached    = limit_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_INIT;
			fault_q     <= FAULT_NONE;
			seen_sent_q <= 1'b0;
			seen_fix_q  <= 1'b0;
			poll_fix_q  <= 1'b0;
			limit_q     <= 1'b0;
			start_q     <= '0;
			last_sent_q <= '0;
			last_fix_q  <= '0;
			last_rec_q  <= '0;
			rec_cnt_q   <= '0;
			sil_cnt_q   <= '0;
			srch_cnt_q  <= '0;
		end else if (fire) begin
			mode_q      <= mode_n;
			fault_q     <= fault_n;
			seen_sent_q <= seen_sent_n;
			seen_fix_q  <= seen_fix_n;
			poll_fix_q  <= poll_fix_n;
			limit_q     <= limit_n;
			start_q     <= start_n;
			last_sent_q <= last_sent_n;
			last_fix_q  <= last_fix_n;
			last_rec_q  <= last_rec_n;
			rec_cnt_q   <= rec_cnt_n;
			sil_cnt_q   <= sil_cnt_n;
			srch_cnt_q  <= srch_cnt_n;
		end
	end

	`GLHS_ASSERT_NOW(a_fault_mode_code, mode_q == MODE_FAULT,
		fault_q == FAULT_LIMIT && limit_q, "fault mode without recovery limit code")
	`GLHS_ASSERT_NOW(a_recovering_counted, mode_q == MODE_RECOVERING,
		rec_cnt_q != 4'd0, "recovering with zero recovery count")
	`GLHS_ASSERT_NOW(a_pulse_source, fire && pulse,
		mode_n == MODE_RECOVERING || item.kind == KIND_START,
		"reset request without recovery or start")
	`GLHS_ASSERT_NEXT(a_start_clears, fire && item.kind == KIND_START,
		rec_cnt_q == 4'd0 && !limit_q && mode_q == MODE_INIT, "start did not clear state")

endmodule

// ===== design/gnss_link_health_supervisor.sv =====
// Channel   | handshake           | payload
// ----------+---------------------+---------------------------------------------
// input     | push / full         | func, now_ms, quality flags, counts, dilutions
// result    | empty / pop         | mode, fault_code, counters, flags
// config    | cfg_wen             | cfg_addr, cfg_wdata
//
// One item per clock sustained while the result queue is not full; a result reaches
// the result ports through the input queue, then the core into the result queue. The
// core handles each item with all timeout compares in parallel. Reset clears
// queues and state and loads the configuration defaults; nothing needs a clearing pass.
// A full result queue stalls the core, and the input queue absorbs it until full.
module gnss_link_health_supervisor import glhs_pkg::*; #(
	parameter int QUEUE_DEPTH  = 2,
	parameter int RESULT_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [2:0]  cfg_addr,
	input  logic [31:0] cfg_wdata,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  func,
	input  logic [31:0] now_ms,
	input  logic        parsed_present,
	input  logic        status_valid,
	input  logic        position_valid,
	input  logic [7:0]  sat_count,
	input  logic [15:0] hdop_centi,
	input  logic [15:0] pdop_centi,
	input  logic [2:0]  fix_kind,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  mode,
	output logic [1:0]  fault_code,
	output logic        fix_accepted,
	output logic        reset_request,
	output logic [3:0]  recovery_total,
	output logic [15:0] silence_timeouts,
	output logic [15:0] search_timeouts,
	output logic        limit_reached
);
	item_t                      item;
	logic                       item_valid, item_take;
	logic                       res_full, res_write;
	result_t                    res_in, res_out;
	logic [$bits(result_t)-1:0] res_data;

	glhs_front #(
		.DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.func           (func),
		.now_ms         (now_ms),
		.parsed_present (parsed_present),
		.status_valid   (status_valid),
		.position_valid (position_valid),
		.sat_count      (sat_count),
		.hdop_centi     (hdop_centi),
		.pdop_centi     (pdop_centi),
		.fix_kind       (fix_kind),
		.item_valid     (item_valid),
		.item           (item),
		.item_take      (item_take)
	);

	glhs_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_addr   (cfg_addr),
		.cfg_wdata  (cfg_wdata),
		.item_valid (item_valid),
		.item       (item),
		.item_take  (item_take),
		.res_full   (res_full),
		.res_write  (res_write),
		.res        (res_in)
	);

	glhs_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (RESULT_DEPTH)
	) u_result_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_write),
		.wr_data (res_in),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (res_data),
		.empty   (empty)
	);

	assign res_out          = result_t'(res_data);
	assign mode             = res_out.mode;
	assign fault_code       = res_out.fault_code;
	assign fix_accepted     = res_out.fix_accepted;
	assign reset_request    = res_out.reset_request;
	assign recovery_total   = res_out.recovery_total;
	assign silence_timeouts = res_out.silence_timeouts;
	assign search_timeouts  = res_out.search_timeouts;
	assign limit_reached    = res_out.limit_reached;

endmodule
